>>> design/rob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_pkg
// Shared sizes, command codes, entry layout and flag update bundle for the
// reorder buffer.
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMD_W = 2;
    localparam int TAG_W = 5;
    localparam int NUM_W = 32;
    localparam int PAY_W = 64;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [PAY_W-1:0] pay;
    } entry_t;

    // Flag updates for one cycle: allocate at the tail, retire the head,
    // mark one entry ready.
    typedef struct packed {
        logic alloc;
        idx_t alloc_idx;
        logic retire;
        idx_t retire_idx;
        logic mark;
        idx_t mark_idx;
    } flag_upd_t;

    // Advance a ring index modulo DEPTH.
    function automatic idx_t next_idx(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

endpackage
`default_nettype wire

>>> design/rob_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_mem
// Entry store: instruction number and payload per slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module rob_mem (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire rob_pkg::idx_t   waddr,
    input  wire rob_pkg::entry_t wdata,
    input  wire rob_pkg::idx_t   raddr,
    output rob_pkg::entry_t      rdata
);
    import rob_pkg::*;

    entry_t ram_reg [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/rob_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_flags
// Per-entry valid and ready bits, cleared by reset.
// ----------------------------------------------------------------------------
module rob_flags (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rob_pkg::flag_upd_t upd,
    output logic [rob_pkg::DEPTH-1:0] valid,
    output logic [rob_pkg::DEPTH-1:0] ready
);
    import rob_pkg::*;

    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ready_reg <= '0;
        end
        else
        begin
            // allocate: set valid, drop any stale ready
            if (upd.alloc)
            begin
                valid_reg[upd.alloc_idx] <= 1'b1;
                ready_reg[upd.alloc_idx] <= 1'b0;
            end
            // retire: ready stays as stored until the slot is reused
            if (upd.retire)
            begin
                valid_reg[upd.retire_idx] <= 1'b0;
            end
            if (upd.mark)
            begin
                ready_reg[upd.mark_idx] <= 1'b1;
            end
        end
    end

    assign valid = valid_reg;
    assign ready = ready_reg;

endmodule
`default_nettype wire

>>> design/reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// reorder_buffer
// Circular reorder buffer: insert at the tail, mark ready by instruction
// number, query a tag's ready bit, retire the head in order.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+--------------------------------------
//  command   | start, busy (taken when   | command, inst_number, inst_payload,
//            | start high and busy low)  | query_tag
//  result    | strobe (one cycle, no     | done_res, entry_tag, tag_is_ready,
//            | back-pressure)            | has_space, head_is_ready,
//            |                           | out_inst_number, out_payload
//
//  Insert and query need no scan; remove passes through a remove state only
//  when it retires the head. Mark ready is a linear scan through the entry
//  memory, one entry per cycle over its single read port, that stops at the
//  first valid match or after the last entry.
//  Reset clears the valid and ready bits and both ring pointers; the entry
//  memory is not cleared, as only valid entries are ever read.
//  The receiver cannot stall: each result shows for one cycle with strobe.
//
module reorder_buffer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [rob_pkg::CMD_W-1:0] command,
    input  wire logic [rob_pkg::NUM_W-1:0] inst_number,
    input  wire logic [rob_pkg::PAY_W-1:0] inst_payload,
    input  wire logic [rob_pkg::TAG_W-1:0] query_tag,
    output logic                           strobe,
    output logic                           done_res,
    output logic [rob_pkg::TAG_W-1:0]      entry_tag,
    output logic                           tag_is_ready,
    output logic                           has_space,
    output logic                           head_is_ready,
    output logic [rob_pkg::NUM_W-1:0]      out_inst_number,
    output logic [rob_pkg::PAY_W-1:0]      out_payload
);
    import rob_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_REMOVE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // control state
    state_t state_reg, state_next;
    idx_t   head_reg, head_next;
    idx_t   tail_reg, tail_next;

    // scan and result registers (no reset needed)
    idx_t             cmp_idx_reg, cmp_idx_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             done_reg, done_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             qready_reg, qready_next;
    logic [NUM_W-1:0] onum_reg, onum_next;
    logic [PAY_W-1:0] opay_reg, opay_next;

    // memory and flag interfaces
    logic             mem_we;
    idx_t             mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;
    flag_upd_t        upd;
    logic [DEPTH-1:0] valid;
    logic [DEPTH-1:0] ready;

    cmd_t cmd;

    assign cmd       = cmd_t'(command);
    assign mem_wdata = '{num: inst_number, pay: inst_payload};

    // Entry memory. Writes happen only on an insert taken in idle; reads are
    // consumed only in the scan and remove states, so the sequencer never
    // lets a write and a used read of the same entry overlap.
    rob_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tail_reg),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rob_flags u_flags (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .valid (valid),
        .ready (ready)
    );

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cmp_idx_next = cmp_idx_reg;
        num_next     = num_reg;
        done_next    = done_reg;
        tag_next     = tag_reg;
        qready_next  = qready_reg;
        onum_next    = onum_reg;
        opay_next    = opay_reg;
        mem_we       = 1'b0;
        upd          = '0;
        // scan reads one entry ahead of the compare
        mem_raddr    = idx_t'(cmp_idx_reg + idx_t'(1));

        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = (cmd == CMD_MARK) ? '0 : head_reg;
                if (start)
                begin
                    // clear the result fields for the new item
                    done_next   = 1'b0;
                    tag_next    = '0;
                    qready_next = 1'b0;
                    onum_next   = '0;
                    opay_next   = '0;
                    num_next    = inst_number;
                    state_next  = ST_DONE;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            // refuse when the tail slot is still in use
                            if (!valid[tail_reg])
                            begin
                                mem_we        = 1'b1;
                                upd.alloc     = 1'b1;
                                upd.alloc_idx = tail_reg;
                                done_next     = 1'b1;
                                tag_next      = TAG_W'(tail_reg);
                                tail_next     = next_idx(tail_reg);
                            end
                        end
                        CMD_MARK:
                        begin
                            cmp_idx_next = '0;
                            state_next   = ST_SCAN;
                        end
                        CMD_QUERY:
                        begin
                            if (int'(query_tag) < DEPTH)
                            begin
                                qready_next = ready[idx_t'(query_tag)];
                            end
                        end
                        CMD_REMOVE:
                        begin
                            // head data is being read this cycle
                            if (valid[head_reg] && ready[head_reg])
                            begin
                                state_next = ST_REMOVE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // lowest valid match wins; stop at the last entry
                if (valid[cmp_idx_reg] && (mem_rdata.num == num_reg))
                begin
                    upd.mark     = 1'b1;
                    upd.mark_idx = cmp_idx_reg;
                    state_next   = ST_DONE;
                end
                else if (cmp_idx_reg == idx_t'(DEPTH - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmp_idx_next = idx_t'(cmp_idx_reg + idx_t'(1));
                end
            end

            ST_REMOVE:
            begin
                upd.retire     = 1'b1;
                upd.retire_idx = head_reg;
                done_next      = 1'b1;
                tag_next       = TAG_W'(head_reg);
                onum_next      = mem_rdata.num;
                opay_next      = mem_rdata.pay;
                head_next      = next_idx(head_reg);
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        num_reg     <= num_next;
        done_reg    <= done_next;
        tag_reg     <= tag_next;
        qready_reg  <= qready_next;
        onum_reg    <= onum_next;
        opay_reg    <= opay_next;
    end

    // Hold busy from acceptance until the result cycle has passed; status
    // flags read the state as it stands after the command.
    assign busy            = (state_reg != ST_IDLE);
    assign strobe          = (state_reg == ST_DONE);
    assign done_res        = done_reg;
    assign entry_tag       = tag_reg;
    assign tag_is_ready    = qready_reg;
    assign has_space       = !valid[tail_reg];
    assign head_is_ready   = valid[head_reg] && ready[head_reg];
    assign out_inst_number = onum_reg;
    assign out_payload     = opay_reg;

endmodule
`default_nettype wire

>>> design/rob_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rob_checker
// Port-level checks on the reorder buffer, attached by bind.
// ----------------------------------------------------------------------------
module rob_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      strobe,
    input wire logic                      done_res,
    input wire logic [rob_pkg::TAG_W-1:0] entry_tag,
    input wire logic                      tag_is_ready,
    input wire logic [rob_pkg::NUM_W-1:0] out_inst_number,
    input wire logic [rob_pkg::PAY_W-1:0] out_payload
);
    import rob_pkg::*;

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only appears while an item is in flight
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result strobe while idle");

    // one result per item, then back to idle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> (!strobe && !busy))
        else $error("result strobe not followed by idle");

    // a failed or non-retiring command carries zero tag and entry data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !done_res) |->
            (entry_tag == '0 && out_inst_number == '0 && out_payload == '0))
        else $error("non-zero result fields without success");

    // a query result that reports a ready tag never also reports success
    a_query_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && tag_is_ready) |-> !done_res)
        else $error("query result flagged as done");

endmodule

bind reorder_buffer rob_checker u_rob_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .strobe          (strobe),
    .done_res        (done_res),
    .entry_tag       (entry_tag),
    .tag_is_ready    (tag_is_ready),
    .out_inst_number (out_inst_number),
    .out_payload     (out_payload)
);
`default_nettype wire

>>> bench/tb_reorder_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_reorder_buffer
// Self-checking bench for the reorder buffer. A queue of commands (a short
// directed opening, then random fill, drain and mixed phases) feeds a
// falling-edge driver. A rising-edge monitor predicts each accepted command
// on a private copy of the buffer state and checks every strobed result,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_reorder_buffer;

    import rob_pkg::*;

    // Cycle budget: about 720 items, each taken as the longest command plus the
    // widest idle gap, still leave ample headroom under this limit.
    localparam int CYCLE_LIMIT  = 200000;
    // Longest single command (mark ready with no match) plus some slack.
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int RANDOM_ITEMS  = 700;
    // Once this few items remain, drive them back to back.
    localparam int QUIET_TAIL    = 120;

    // One command as presented on the input ports.
    typedef struct packed {
        cmd_t             command;
        logic [NUM_W-1:0] num;
        logic [PAY_W-1:0] pay;
        logic [TAG_W-1:0] qtag;
    } rob_req_t;

    // One result as strobed on the output ports.
    typedef struct packed {
        logic             done;
        logic [TAG_W-1:0] tag;
        logic             qready;
        logic             space;
        logic             head_rdy;
        logic [NUM_W-1:0] num;
        logic [PAY_W-1:0] pay;
    } rob_resp_t;

    // Whole buffer contents, so the planner and the checker can each keep one.
    typedef struct packed {
        logic [DEPTH-1:0]            valid;
        logic [DEPTH-1:0]            ready;
        logic [DEPTH-1:0][NUM_W-1:0] num;
        logic [DEPTH-1:0][PAY_W-1:0] pay;
        idx_t                        head;
        idx_t                        tail;
    } rob_state_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } phase_mode_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [CMD_W-1:0] command;
    logic [NUM_W-1:0] inst_number;
    logic [PAY_W-1:0] inst_payload;
    logic [TAG_W-1:0] query_tag;
    logic             strobe;
    logic             done_res;
    logic [TAG_W-1:0] entry_tag;
    logic             tag_is_ready;
    logic             has_space;
    logic             head_is_ready;
    logic [NUM_W-1:0] out_inst_number;
    logic [PAY_W-1:0] out_payload;

    rob_req_t   pending_reqs[$];
    rob_resp_t  expected_resps[$];
    rob_state_t plan_state;     // state as the command planner sees it
    rob_state_t model_state;    // state as the checker predicts it
    bit         item_taken;
    int         gap_left;
    int         total_items;
    int         accepted_count;
    int         mismatch_count;
    int         cycle_count;

    reorder_buffer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .inst_number     (inst_number),
        .inst_payload    (inst_payload),
        .query_tag       (query_tag),
        .strobe          (strobe),
        .done_res        (done_res),
        .entry_tag       (entry_tag),
        .tag_is_ready    (tag_is_ready),
        .has_space       (has_space),
        .head_is_ready   (head_is_ready),
        .out_inst_number (out_inst_number),
        .out_payload     (out_payload)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Buffer behaviour: apply one command to a state and give its result.
    // Flags in the result reflect the state after the command.
    // ------------------------------------------------------------------------
    function automatic idx_t ring_step(input idx_t i);
        return (int'(i) == DEPTH - 1) ? idx_t'(0) : idx_t'(int'(i) + 1);
    endfunction

    function automatic void rob_apply(inout rob_state_t s, input rob_req_t r,
                                      output rob_resp_t o);
        bit found;
        found = 1'b0;
        o = '0;
        case (r.command)
            CMD_INSERT:
            begin
                // Full when the tail slot is still occupied: store nothing.
                if (!s.valid[s.tail])
                begin
                    s.valid[s.tail] = 1'b1;
                    s.ready[s.tail] = 1'b0;
                    s.num[s.tail]   = r.num;
                    s.pay[s.tail]   = r.pay;
                    o.done = 1'b1;
                    o.tag  = s.tail;
                    s.tail = ring_step(s.tail);
                end
            end
            CMD_MARK:
            begin
                // Lowest matching valid index wins; no match leaves all alone.
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (!found && s.valid[i] && s.num[i] == r.num)
                    begin
                        s.ready[i] = 1'b1;
                        found = 1'b1;
                    end
                end
            end
            CMD_QUERY:
            begin
                // Ready bits survive retirement, so report them as stored.
                o.qready = (int'(r.qtag) < DEPTH) && s.ready[r.qtag];
            end
            default:
            begin
                if (s.valid[s.head] && s.ready[s.head])
                begin
                    s.valid[s.head] = 1'b0;
                    o.done = 1'b1;
                    o.tag  = s.head;
                    o.num  = s.num[s.head];
                    o.pay  = s.pay[s.head];
                    s.head = ring_step(s.head);
                end
            end
        endcase
        o.space    = !s.valid[s.tail];
        o.head_rdy = s.valid[s.head] && s.ready[s.head];
    endfunction

    // ------------------------------------------------------------------------
    // Command planning
    // ------------------------------------------------------------------------
    function automatic rob_req_t make_req(input cmd_t c, input logic [NUM_W-1:0] n,
                                          input logic [PAY_W-1:0] p,
                                          input logic [TAG_W-1:0] q);
        rob_req_t r;
        r.command = c;
        r.num     = n;
        r.pay     = p;
        r.qtag    = q;
        return r;
    endfunction

    // Advance the planner's view and hold the command for the driver.
    task automatic queue_req(input rob_req_t r);
        rob_resp_t unused;
        rob_apply(plan_state, r, unused);
        pending_reqs.push_back(r);
    endtask

    // Pick a random command, mostly well formed: marks aim at live entries,
    // preferring the head so that drains make progress.
    function automatic rob_req_t plan_req(input phase_mode_t mode);
        rob_req_t r;
        int       pick;
        int       slot;
        int       sel;
        pick = $urandom_range(0, 99);
        r.num  = $urandom;
        r.pay  = {$urandom, $urandom};
        r.qtag = TAG_W'($urandom_range(0, DEPTH - 1));
        case (mode)
            MODE_FILL:  sel = (pick < 70) ? 0 : (pick < 85) ? 1 : (pick < 93) ? 2 : 3;
            MODE_DRAIN: sel = (pick < 10) ? 0 : (pick < 50) ? 1 : (pick < 60) ? 2 : 3;
            default:    sel = pick / 25;
        endcase
        case (sel)
            0:
            begin
                r.command = CMD_INSERT;
                // Draw from a narrow range now and then to make duplicates.
                if ($urandom_range(0, 3) == 0)
                    r.num = $urandom_range(0, 7);
            end
            1:
            begin
                r.command = CMD_MARK;
                pick = $urandom_range(0, 9);
                slot = $urandom_range(0, DEPTH - 1);
                if (pick < 5 && plan_state.valid[plan_state.head])
                    r.num = plan_state.num[plan_state.head];
                else if (pick < 9 && plan_state.valid[slot])
                    r.num = plan_state.num[slot];
            end
            2:
            begin
                r.command = CMD_QUERY;
                if ($urandom_range(0, 2) == 0)
                    r.qtag = plan_state.head;
            end
            default:
                r.command = CMD_REMOVE;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold an item until taken,
    // then either idle for a random burst or present the next one.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : driver
        rob_req_t nxt;
        if (rst_n && (!start || item_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_reqs.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            begin
                // This cycle counts as the first of an idle burst; gap_left holds the rest.
                gap_left = $urandom_range(0, 5);
                start <= 1'b0;
            end
            else
            begin
                nxt = pending_reqs.pop_front();
                start        <= 1'b1;
                command      <= nxt.command;
                inst_number  <= nxt.num;
                inst_payload <= nxt.pay;
                query_tag    <= nxt.qtag;
            end
        end
    end

    // Report one field mismatch with the time and both values.
    task automatic check_field(input string name, input logic [PAY_W-1:0] want,
                               input logic [PAY_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample on the rising edge. Predict each accepted item at the
    // edge that takes it, and check each strobed result against the oldest
    // prediction still waiting.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        rob_req_t  seen;
        rob_resp_t want;
        item_taken = rst_n && start && !busy;
        if (item_taken)
        begin
            seen = make_req(cmd_t'(command), inst_number, inst_payload, query_tag);
            rob_apply(model_state, seen, want);
            expected_resps.push_back(want);
            accepted_count++;
        end
        if (rst_n && strobe)
        begin
            if (expected_resps.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result strobed with none expected, expected none, got tag %0h",
                         $time, entry_tag);
            end
            else
            begin
                want = expected_resps.pop_front();
                check_field("done_res",        PAY_W'(want.done),     PAY_W'(done_res));
                check_field("entry_tag",       PAY_W'(want.tag),      PAY_W'(entry_tag));
                check_field("tag_is_ready",    PAY_W'(want.qready),   PAY_W'(tag_is_ready));
                check_field("has_space",       PAY_W'(want.space),    PAY_W'(has_space));
                check_field("head_is_ready",   PAY_W'(want.head_rdy), PAY_W'(head_is_ready));
                check_field("out_inst_number", PAY_W'(want.num),
                            PAY_W'(out_inst_number));
                check_field("out_payload",     want.pay,              out_payload);
            end
        end
    end

    // Watchdog: end a hung run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        phase_mode_t mode;
        logic [NUM_W-1:0] ones_num;
        logic [PAY_W-1:0] ones_pay;
        ones_num = '1;
        ones_pay = '1;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = CMD_INSERT;
        inst_number  = '0;
        inst_payload = '0;
        query_tag    = '0;
        item_taken   = 1'b0;
        gap_left     = 0;
        accepted_count = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        plan_state  = '0;
        model_state = '0;
        mode = MODE_FILL;

        // Directed opening: empty-buffer corners, extremes, duplicates,
        // lowest-match marking, head not ready, and retired-entry queries.
        queue_req(make_req(CMD_QUERY,  '0, '0, '0));
        queue_req(make_req(CMD_QUERY,  '0, '0, TAG_W'(DEPTH - 1)));
        queue_req(make_req(CMD_REMOVE, '0, '0, '0));
        queue_req(make_req(CMD_MARK,   '0, '0, '0));
        queue_req(make_req(CMD_INSERT, '0, '0, '0));
        queue_req(make_req(CMD_INSERT, ones_num, ones_pay, '0));
        queue_req(make_req(CMD_INSERT, ones_num, 64'h0123_4567_89ab_cdef, '0));
        queue_req(make_req(CMD_MARK,   ones_num, '0, '0));
        queue_req(make_req(CMD_QUERY,  '0, '0, 5'd1));
        queue_req(make_req(CMD_QUERY,  '0, '0, 5'd2));
        queue_req(make_req(CMD_REMOVE, '0, '0, '0));
        queue_req(make_req(CMD_MARK,   32'd12345, '0, '0));
        queue_req(make_req(CMD_MARK,   '0, '0, '0));
        queue_req(make_req(CMD_REMOVE, ones_num, ones_pay, ones_pay[TAG_W-1:0]));
        queue_req(make_req(CMD_REMOVE, '0, '0, '0));
        queue_req(make_req(CMD_QUERY,  '0, '0, '0));
        queue_req(make_req(CMD_REMOVE, '0, '0, '0));
        queue_req(make_req(CMD_MARK,   ones_num, '0, '0));
        queue_req(make_req(CMD_REMOVE, '0, '0, '0));

        // Random phases: switch the command mix every 40 items so the buffer
        // fills to full, wraps, and drains back to empty repeatedly.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                mode = phase_mode_t'($urandom_range(0, 2));
            queue_req(plan_req(mode));
        end
        total_items = pending_reqs.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_count < total_items)
            @(posedge clk);
        while (expected_resps.size() != 0)
            @(posedge clk);
        // Let any stray late result show up before judging.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
design/rob_pkg.sv
design/rob_mem.sv
design/rob_flags.sv
design/reorder_buffer.sv
design/rob_checker.sv
bench/tb_reorder_buffer.sv
